/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; every macro expects signal clk in scope, SBAVG_ASSERT also rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SBAVG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define SBAVG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sbavg_pkg.sv */
// shared types and constants of the spike rejecting burst averager
// no dependencies
package sbavg_pkg;

  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 2;
  localparam int STEP_W    = 12;
  localparam int RETRY_W   = 8;
  localparam int SCALE_W   = 12;
  localparam int PCT_W     = 7;

  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP_DIFF = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE    = 2'd2;

  localparam logic [STEP_W-1:0]  MAX_STEP_DIFF_RST = 12'd200;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = 8'd3;
  localparam logic [SCALE_W-1:0] FULL_SCALE_RST    = 12'd4095;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/sbavg_ram.sv */
// generic single write port ram with registered read
// no dependencies
module sbavg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sbavg_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on sbavg_pkg for the status struct
module sbavg_div #(
  parameter int DIVIDEND_W = 19,
  parameter int DIVISOR_W  = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIVIDEND_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]    divisor,
  output logic [DIVIDEND_W-1:0]   quotient,
  output sbavg_pkg::div_status_t  status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      count  <= '0;
    end else begin
      status.done <= !start && status.busy && count == CNT_W'(1);
      if (start) begin
        status.busy <= 1'b1;
        count       <= CNT_W'(DIVIDEND_W);
      end else if (status.busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (status.busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
      rem      <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

/* hw/rtl/spike_rejecting_burst_averager.sv */
// top level of the spike rejecting burst averager
// depends on sbavg_pkg, sbavg_div and sbavg_ram
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   cfg      | cfg_write              | cfg_index, cfg_data
//   in       | in_valid / in_ready    | raw_reading
//   out      | out_valid / out_ready  | burst_mean, window_mean, light_percent
//
// a reading that does not end a burst leaves in_ready high
// a reading that ends a burst holds in_ready low through BDIV, PUSH, WSTART,
// WDIV, PSTART, PDIV and OUT; the serial percent divider (one quotient bit a
// cycle) runs in PDIV; the burst and window means take one reciprocal multiply each
// synchronous reset returns the window to empty; no clearing pass is needed
// a full output register holds the block at the end of the next burst only
module spike_rejecting_burst_averager #(
  parameter int BURST_LENGTH = 8,
  parameter int WINDOW_DEPTH = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sbavg_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [sbavg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          raw_reading,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_BITS-1:0]          burst_mean,
  output logic [SAMPLE_BITS-1:0]          window_mean,
  output logic [sbavg_pkg::PCT_W-1:0]     light_percent
);

  localparam int POS_W  = BURST_LENGTH > 1 ? $clog2(BURST_LENGTH) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(BURST_LENGTH);
  localparam int PTR_W  = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WS_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int DIV_W  = SAMPLE_BITS + sbavg_pkg::PCT_W;
  localparam int BSH    = SUM_W + $clog2(BURST_LENGTH);
  localparam int WSH    = WS_W + $clog2(WINDOW_DEPTH);
  localparam int CMP_W  = SAMPLE_BITS > sbavg_pkg::STEP_W ? SAMPLE_BITS :
                          sbavg_pkg::STEP_W;

  // rounded-up reciprocals, exact for every sum that fits the sum width
  localparam logic [SUM_W:0] BURST_RECIP =
    (SUM_W + 1)'(((64'd1 << BSH) + 64'(BURST_LENGTH - 1)) / 64'(BURST_LENGTH));
  localparam logic [WS_W:0] WINDOW_RECIP =
    (WS_W + 1)'(((64'd1 << WSH) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BDIV   = 3'd1;
  localparam logic [2:0] ST_PUSH   = 3'd2;
  localparam logic [2:0] ST_WSTART = 3'd3;
  localparam logic [2:0] ST_WDIV   = 3'd4;
  localparam logic [2:0] ST_PSTART = 3'd5;
  localparam logic [2:0] ST_PDIV   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state;

  logic [sbavg_pkg::STEP_W-1:0]  max_step_diff;
  logic [sbavg_pkg::RETRY_W-1:0] retry_limit;
  logic [sbavg_pkg::SCALE_W-1:0] full_scale;

  logic [SAMPLE_BITS-1:0]        last_accepted;
  logic [sbavg_pkg::RETRY_W-1:0] retries_left;
  logic [POS_W-1:0]              burst_position;
  logic [SUM_W-1:0]              burst_sum;
  logic [PTR_W-1:0]              head;
  logic [FILL_W-1:0]             fill_count;
  logic [WS_W-1:0]               filled_sum;
  logic [WS_W-1:0]               wtotal;
  logic [SAMPLE_BITS-1:0]        mean;
  logic [SAMPLE_BITS-1:0]        wmean;
  logic [sbavg_pkg::PCT_W-1:0]   pct;

  logic                   take;
  logic [SAMPLE_BITS-1:0] jump;
  logic                   reject;
  logic                   last_of_burst;
  logic [SUM_W-1:0]       sum_total;
  logic                   full;
  logic [WS_W:0]          push_sum;
  logic [FILL_W-1:0]      empty_slots;
  logic [WS_W-1:0]        window_total;
  logic [2*SUM_W:0]       burst_prod;
  logic [2*WS_W:0]        window_prod;
  logic [DIV_W-1:0]       scaled;
  logic [SAMPLE_BITS-1:0] evicted;
  logic                   load_out;

  logic                   div_start;
  logic [DIV_W-1:0]       div_quotient;
  sbavg_pkg::div_status_t div_status;

  assign in_ready      = state == ST_IDLE;
  assign take          = in_valid && in_ready;
  assign jump          = raw_reading >= last_accepted ? raw_reading - last_accepted :
                         last_accepted - raw_reading;
  assign reject        = burst_position != '0 &&
                         CMP_W'(jump) >= CMP_W'(max_step_diff) && retries_left != '0;
  assign last_of_burst = burst_position == POS_W'(BURST_LENGTH - 1);
  assign sum_total     = burst_sum + SUM_W'(raw_reading);
  assign full          = fill_count == FILL_W'(WINDOW_DEPTH);
  assign push_sum      = ({1'b0, filled_sum} + (WS_W + 1)'(mean)) -
                         (full ? (WS_W + 1)'(evicted) : '0);
  assign empty_slots   = FILL_W'(WINDOW_DEPTH) - fill_count;
  assign window_total  = filled_sum + WS_W'(empty_slots) * WS_W'(mean);
  assign burst_prod    = (2 * SUM_W + 1)'(burst_sum) * (2 * SUM_W + 1)'(BURST_RECIP);
  assign window_prod   = (2 * WS_W + 1)'(wtotal) * (2 * WS_W + 1)'(WINDOW_RECIP);
  assign scaled        = DIV_W'(wmean) * DIV_W'(sbavg_pkg::PCT_SCALE);
  assign load_out      = state == ST_OUT && (!out_valid || out_ready);
  assign div_start     = state == ST_PSTART;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step_diff <= sbavg_pkg::MAX_STEP_DIFF_RST;
      retry_limit   <= sbavg_pkg::RETRY_LIMIT_RST;
      full_scale    <= sbavg_pkg::FULL_SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sbavg_pkg::REG_MAX_STEP_DIFF: max_step_diff <= cfg_data[sbavg_pkg::STEP_W-1:0];
        sbavg_pkg::REG_RETRY_LIMIT:   retry_limit   <= cfg_data[sbavg_pkg::RETRY_W-1:0];
        sbavg_pkg::REG_FULL_SCALE:    full_scale    <= cfg_data[sbavg_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_accepted  <= '0;
      retries_left   <= sbavg_pkg::RETRY_LIMIT_RST;
      burst_position <= '0;
      burst_sum      <= '0;
      head           <= '0;
      fill_count     <= '0;
      filled_sum     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (reject) begin
              retries_left <= retries_left - 1'b1;
            end else begin
              last_accepted <= raw_reading;
              retries_left  <= retry_limit;
              burst_sum     <= sum_total;
              if (last_of_burst) begin
                burst_position <= '0;
                state          <= ST_BDIV;
              end else begin
                burst_position <= burst_position + 1'b1;
              end
            end
          end
        end
        ST_BDIV: begin
          burst_sum <= '0;
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          filled_sum <= push_sum[WS_W-1:0];
          if (!full) begin
            fill_count <= fill_count + 1'b1;
          end
          head  <= head == PTR_W'(WINDOW_DEPTH - 1) ? '0 : head + 1'b1;
          state <= ST_WSTART;
        end
        ST_WSTART: state <= ST_WDIV;
        ST_WDIV: state <= ST_PSTART;
        ST_PSTART: state <= ST_PDIV;
        ST_PDIV: begin
          if (div_status.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_BDIV) begin
      mean <= burst_prod[BSH +: SAMPLE_BITS];
    end
    if (state == ST_WSTART) begin
      wtotal <= window_total;
    end
    if (state == ST_WDIV) begin
      wmean <= window_prod[WSH +: SAMPLE_BITS];
    end
    if (state == ST_PDIV && div_status.done) begin
      pct <= div_quotient > DIV_W'(sbavg_pkg::PCT_MAX) ? sbavg_pkg::PCT_MAX :
             div_quotient[sbavg_pkg::PCT_W-1:0];
    end
    if (load_out) begin
      burst_mean    <= mean;
      window_mean   <= wmean;
      light_percent <= pct;
    end
  end

  sbavg_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (sbavg_pkg::SCALE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled),
    .divisor  (full_scale),
    .quotient (div_quotient),
    .status   (div_status)
  );

  sbavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (state == ST_PUSH),
    .waddr (head),
    .wdata (mean),
    .raddr (head),
    .rdata (evicted)
  );

endmodule

/* hw/rtl/sbavg_checker.sv */
// port level checks of the spike rejecting burst averager, bound to the top level
// depends on assert_macros.svh and sbavg_pkg
`include "assert_macros.svh"

module sbavg_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [SAMPLE_BITS-1:0]      burst_mean,
  input logic [SAMPLE_BITS-1:0]      window_mean,
  input logic [sbavg_pkg::PCT_W-1:0] light_percent
);

  `SBAVG_ASSERT_ALWAYS(a_reset_state, rst |=> in_ready && !out_valid, "bad state after reset")
  `SBAVG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(burst_mean) && $stable(window_mean) && $stable(light_percent), "stalled result changed")
  `SBAVG_ASSERT(a_pct_range, out_valid |-> light_percent <= sbavg_pkg::PCT_MAX, "percent above full scale")
  `SBAVG_ASSERT(a_new_result_idle, $rose(out_valid) |-> in_ready, "result issued while busy")

endmodule

bind spike_rejecting_burst_averager sbavg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sbavg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .burst_mean    (burst_mean),
  .window_mean   (window_mean),
  .light_percent (light_percent)
);
